/* hdl/sbi_pkg.sv */
// Shared types and constants for the segment and box crossing pipeline.
package sbi_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int QUOT_W      = COORD_WIDTH + 2;
    localparam int DIV_STEPS   = DIFF_W;
    localparam int LANE_STAGES = DIV_STEPS + 3;
    localparam int PIPE_STAGES = LANE_STAGES + 4;
    localparam int NUM_SIDES   = 4;

    localparam int SIDE_LEFT   = 0;
    localparam int SIDE_RIGHT  = 1;
    localparam int SIDE_BOTTOM = 2;
    localparam int SIDE_TOP    = 3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] box_low_x;
        logic signed [COORD_WIDTH-1:0] box_low_y;
        logic signed [COORD_WIDTH-1:0] box_high_x;
        logic signed [COORD_WIDTH-1:0] box_high_y;
    } query_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] cross_x;
        logic signed [COORD_WIDTH-1:0] cross_y;
        logic                          miss;
    } result_t;

endpackage

/* hdl/sbi_lane.sv */
// One side of the box: pipelined trunc(a * b / c) with overflow and zero-divisor checks.
module sbi_lane (
    input  logic                                  clk,
    input  logic [sbi_pkg::LANE_STAGES-1:0]       en,
    input  logic signed [sbi_pkg::DIFF_W-1:0]     num_a,
    input  logic signed [sbi_pkg::DIFF_W-1:0]     num_b,
    input  logic signed [sbi_pkg::DIFF_W-1:0]     den,
    input  logic                                  side_try,
    output logic signed [sbi_pkg::QUOT_W-1:0]     quot,
    output logic                                  quot_ok
);

    localparam int DW = sbi_pkg::DIFF_W;
    localparam int PW = sbi_pkg::PROD_W;
    localparam int QW = sbi_pkg::QUOT_W;
    localparam int NS = sbi_pkg::DIV_STEPS;

    logic [DW-1:0] mag_a;
    logic [DW-1:0] mag_b;
    logic [DW-1:0] mag_d;

    logic [PW-1:0] prod_reg;
    logic [DW-1:0] den0_reg;
    logic          neg0_reg;
    logic          ok0_reg;

    logic [DW-1:0] rem_reg [0:NS];
    logic [DW-1:0] low_reg [0:NS];
    logic [DW-1:0] quo_reg [0:NS];
    logic [DW-1:0] den_reg [0:NS];
    logic          neg_reg [0:NS];
    logic          ok_reg  [0:NS];

    logic          over;
    logic signed [QW-1:0] quot_next;
    logic signed [QW-1:0] quot_reg;
    logic                 quot_ok_reg;

    // Magnitudes; the most negative value maps to its true magnitude as unsigned.
    assign mag_a = num_a[DW-1] ? DW'(-num_a) : DW'(num_a);
    assign mag_b = num_b[DW-1] ? DW'(-num_b) : DW'(num_b);
    assign mag_d = den[DW-1]   ? DW'(-den)   : DW'(den);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= PW'(mag_a) * PW'(mag_b);
            den0_reg <= mag_d;
            neg0_reg <= num_a[DW-1] ^ num_b[DW-1] ^ den[DW-1];
            ok0_reg  <= side_try && (den != '0);
        end
    end

    // The quotient fits in DW bits only when the upper product half is below the divisor.
    // Any larger quotient lands outside every box span, so the side is dropped.
    assign over = prod_reg[PW-1:DW] >= den0_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rem_reg[0] <= prod_reg[PW-1:DW];
            low_reg[0] <= prod_reg[DW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den0_reg;
            neg_reg[0] <= neg0_reg;
            ok_reg[0]  <= ok0_reg && !over;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar j = 0; j < NS; j++)
    begin : g_step
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;

        assign trial    = {rem_reg[j], low_reg[j][DW-1]};
        assign ge       = trial >= {1'b0, den_reg[j]};
        assign rem_next = ge ? DW'(trial - {1'b0, den_reg[j]}) : trial[DW-1:0];

        always_ff @(posedge clk)
        begin
            if (en[j + 2])
            begin
                rem_reg[j + 1] <= rem_next;
                low_reg[j + 1] <= {low_reg[j][DW-2:0], 1'b0};
                quo_reg[j + 1] <= {quo_reg[j][DW-2:0], ge};
                den_reg[j + 1] <= den_reg[j];
                neg_reg[j + 1] <= neg_reg[j];
                ok_reg[j + 1]  <= ok_reg[j];
            end
        end
    end

    assign quot_next = neg_reg[NS] ? -$signed(QW'(quo_reg[NS])) : $signed(QW'(quo_reg[NS]));

    always_ff @(posedge clk)
    begin
        if (en[sbi_pkg::LANE_STAGES-1])
        begin
            quot_reg    <= quot_next;
            quot_ok_reg <= ok_reg[NS];
        end
    end

    assign quot    = quot_reg;
    assign quot_ok = quot_ok_reg;

endmodule

/* hdl/segment_box_intersect.sv */
// Top level of the segment and box crossing pipeline.
//
// Takes one query item per cycle (a segment from an inside start point to an outside
// end point, plus an axis-aligned box) and returns one result item per query: the point
// where the segment crosses the box border. The sides are tried in the order left,
// right, bottom, top; a side counts only when the end point lies strictly beyond it,
// its divisor is nonzero, and the crossing coordinate lies within the box span, bounds
// included. The crossing coordinate is start + trunc(a * b / c), exact and truncated
// toward zero. When no side qualifies, miss is set and both coordinates read zero.
// The pipeline is COORD_WIDTH + 8 stages deep and accepts a new item every cycle unless
// the pipe is stalled and full. Its length is set by the restoring divider in each
// of the four side lanes, which resolves one quotient bit per stage. Every stage keeps
// its own valid bit and a stage loads whenever some stage at or after it is empty or
// the output is taken, so bubbles close up and a stalled result never drops an item.
module segment_box_intersect (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    output logic             query_stall,
    input  sbi_pkg::query_t  query,
    output logic             result_valid,
    input  logic             result_stall,
    output sbi_pkg::result_t result
);

    localparam int W   = sbi_pkg::COORD_WIDTH;
    localparam int DW  = sbi_pkg::DIFF_W;
    localparam int QW  = sbi_pkg::QUOT_W;
    localparam int LS  = sbi_pkg::LANE_STAGES;
    localparam int P   = sbi_pkg::PIPE_STAGES;
    localparam int NSD = sbi_pkg::NUM_SIDES;
    localparam int CMP = LS + 2;
    localparam int OUT = LS + 3;

    // Stage occupancy and per-stage load enables.
    logic [P-1:0] vld_reg;
    logic [P-1:0] vld_next;
    logic [P-1:0] rdy;

    // The query rides along with its arithmetic up to the compare stage.
    sbi_pkg::query_t pipe_reg [0:CMP];

    // Operand stage.
    logic signed [DW-1:0] num_reg [NSD];
    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dy_reg;
    logic [NSD-1:0]       try_reg;

    // Lane results.
    logic signed [QW-1:0] quot [NSD];
    logic [NSD-1:0]       quot_ok;

    // Compare stage.
    logic signed [W+2:0]  along_next [NSD];
    logic [NSD-1:0]       hit_next;
    logic [W-1:0]         along_reg [NSD];
    logic [NSD-1:0]       hit_reg;

    sbi_pkg::result_t     result_next;
    sbi_pkg::result_t     result_reg;

    sbi_pkg::query_t      q0;
    sbi_pkg::query_t      qc;

    function automatic logic signed [DW-1:0] ext_d(input logic [W-1:0] v);
        return {v[W-1], v};
    endfunction

    function automatic logic signed [W+2:0] ext_c(input logic [W-1:0] v);
        return {{3{v[W-1]}}, v};
    endfunction

    // A stage may load when any stage from it to the output has room, or the output drains.
    always_comb
    begin
        for (int k = 0; k < P; k++)
        begin
            rdy[k] = !result_stall || ((~vld_reg >> k) != '0);
        end
        vld_next = {vld_reg[P-2:0], query_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < P; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign query_stall = !rdy[0];

    // Query delay line.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pipe_reg[0] <= query;
        end
        for (int k = 1; k <= CMP; k++)
        begin
            if (rdy[k])
            begin
                pipe_reg[k] <= pipe_reg[k - 1];
            end
        end
    end

    assign q0 = pipe_reg[0];

    // Differences and the side-beyond tests. Left and right share the divisor
    // start_x - end_x; bottom and top share start_y - end_y.
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            num_reg[sbi_pkg::SIDE_LEFT]   <= ext_d(q0.box_low_x)  - ext_d(q0.start_x);
            num_reg[sbi_pkg::SIDE_RIGHT]  <= ext_d(q0.box_high_x) - ext_d(q0.start_x);
            num_reg[sbi_pkg::SIDE_BOTTOM] <= ext_d(q0.box_low_y)  - ext_d(q0.start_y);
            num_reg[sbi_pkg::SIDE_TOP]    <= ext_d(q0.box_high_y) - ext_d(q0.start_y);
            dx_reg <= ext_d(q0.start_x) - ext_d(q0.end_x);
            dy_reg <= ext_d(q0.start_y) - ext_d(q0.end_y);
            try_reg[sbi_pkg::SIDE_LEFT]   <= q0.end_x < q0.box_low_x;
            try_reg[sbi_pkg::SIDE_RIGHT]  <= q0.end_x > q0.box_high_x;
            try_reg[sbi_pkg::SIDE_BOTTOM] <= q0.end_y < q0.box_low_y;
            try_reg[sbi_pkg::SIDE_TOP]    <= q0.end_y > q0.box_high_y;
        end
    end

    // Four side lanes: vertical sides scale dy by dx, horizontal sides scale dx by dy.
    for (genvar s = 0; s < NSD; s++)
    begin : g_side
        sbi_lane u_lane (
            .clk      (clk),
            .en       (rdy[LS+1:2]),
            .num_a    (num_reg[s]),
            .num_b    ((s < sbi_pkg::SIDE_BOTTOM) ? dy_reg : dx_reg),
            .den      ((s < sbi_pkg::SIDE_BOTTOM) ? dx_reg : dy_reg),
            .side_try (try_reg[s]),
            .quot     (quot[s]),
            .quot_ok  (quot_ok[s])
        );
    end

    assign qc = pipe_reg[LS + 1];

    // Crossing coordinate along each side and the span check.
    always_comb
    begin
        along_next[sbi_pkg::SIDE_LEFT]   = ext_c(qc.start_y) + (W+3)'(quot[sbi_pkg::SIDE_LEFT]);
        along_next[sbi_pkg::SIDE_RIGHT]  = ext_c(qc.start_y) + (W+3)'(quot[sbi_pkg::SIDE_RIGHT]);
        along_next[sbi_pkg::SIDE_BOTTOM] = ext_c(qc.start_x) + (W+3)'(quot[sbi_pkg::SIDE_BOTTOM]);
        along_next[sbi_pkg::SIDE_TOP]    = ext_c(qc.start_x) + (W+3)'(quot[sbi_pkg::SIDE_TOP]);
        for (int s = 0; s < NSD; s++)
        begin
            if (s < sbi_pkg::SIDE_BOTTOM)
            begin
                hit_next[s] = quot_ok[s] && (along_next[s] >= ext_c(qc.box_low_y))
                              && (along_next[s] <= ext_c(qc.box_high_y));
            end
            else
            begin
                hit_next[s] = quot_ok[s] && (along_next[s] >= ext_c(qc.box_low_x))
                              && (along_next[s] <= ext_c(qc.box_high_x));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[CMP])
        begin
            for (int s = 0; s < NSD; s++)
            begin
                along_reg[s] <= along_next[s][W-1:0];
            end
            hit_reg <= hit_next;
        end
    end

    // First qualifying side in the fixed order wins.
    always_comb
    begin
        result_next.cross_x = '0;
        result_next.cross_y = '0;
        result_next.miss    = 1'b1;
        if (hit_reg[sbi_pkg::SIDE_LEFT])
        begin
            result_next.cross_x = pipe_reg[CMP].box_low_x;
            result_next.cross_y = along_reg[sbi_pkg::SIDE_LEFT];
            result_next.miss    = 1'b0;
        end
        else if (hit_reg[sbi_pkg::SIDE_RIGHT])
        begin
            result_next.cross_x = pipe_reg[CMP].box_high_x;
            result_next.cross_y = along_reg[sbi_pkg::SIDE_RIGHT];
            result_next.miss    = 1'b0;
        end
        else if (hit_reg[sbi_pkg::SIDE_BOTTOM])
        begin
            result_next.cross_x = along_reg[sbi_pkg::SIDE_BOTTOM];
            result_next.cross_y = pipe_reg[CMP].box_low_y;
            result_next.miss    = 1'b0;
        end
        else if (hit_reg[sbi_pkg::SIDE_TOP])
        begin
            result_next.cross_x = along_reg[sbi_pkg::SIDE_TOP];
            result_next.cross_y = pipe_reg[CMP].box_high_y;
            result_next.miss    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[OUT])
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = vld_reg[P-1];

`ifndef NO_ASSERTIONS
    // A miss always reports a zero point.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.miss |-> (result.cross_x == '0) && (result.cross_y == '0))
        else $error("miss result carries a nonzero point");

    // The input stalls only when every stage holds an item.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall |-> (&vld_reg))
        else $error("input stalled while the pipeline has a free stage");

    // An item ready to leave the compare stage reaches the output register.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[P-2] && rdy[P-1] |=> result_valid)
        else $error("item lost between compare stage and output");
`endif

endmodule
